### rtl/core/cts_pkg.sv
`default_nettype none

package cts_pkg;

   // menu position, also the menu_state code on the result word
   typedef enum logic [3:0] {
      POS_RUN      = 4'd0,
      POS_DATE     = 4'd1,
      POS_MONTH    = 4'd2,
      POS_YEAR     = 4'd3,
      POS_WDAY     = 4'd4,
      POS_HOUR     = 4'd5,
      POS_MIN      = 4'd6,
      POS_SEC      = 4'd7,
      POS_ON_HOUR  = 4'd8,
      POS_ON_MIN   = 4'd9,
      POS_OFF_HOUR = 4'd10,
      POS_OFF_MIN  = 4'd11
   } pos_type;

   typedef enum logic [2:0] {
      MODE_SNAP  = 3'd0,
      MODE_CLOCK = 3'd1,
      MODE_START = 3'd2,
      MODE_STOP  = 3'd3,
      MODE_PLUS  = 3'd4,
      MODE_MINUS = 3'd5,
      MODE_SET   = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      TGT_NONE  = 2'd0,
      TGT_CLOCK = 2'd1,
      TGT_NV    = 2'd2
   } target_type;

   typedef enum logic [1:0] {
      CMD_SINGLE = 2'd0,
      CMD_CLOCK  = 2'd1,
      CMD_NV     = 2'd2
   } cmd_kind_type;

   localparam int CLK_REGS = 7;
   localparam int NV_REGS  = 2;
   localparam logic [2:0] LAST_CLK_REG = 3'(CLK_REGS - 1);
   localparam logic [2:0] LAST_NV_REG  = 3'(NV_REGS - 1);
   localparam logic [2:0] WDAY_REG     = 3'd3;
   localparam logic [2:0] NV_ON_BASE   = 3'd0;
   localparam logic [2:0] NV_OFF_BASE  = 3'd2;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] sec_bcd;
      logic [7:0] min_bcd;
      logic [7:0] hour_bcd;
      logic [7:0] weekday_raw;
      logic [7:0] date_bcd;
      logic [7:0] month_bcd;
      logic [7:0] year_bcd;
   } req_type;

   typedef struct packed {
      logic [3:0] menu_state;
      logic [7:0] shown_value;
      logic [1:0] write_target;
      logic [2:0] write_address;
      logic [7:0] write_data;
      logic       last;
   } rsp_type;

   // classified work handed from front to back
   typedef struct packed {
      cmd_kind_type          kind;
      logic [3:0]            state;
      logic [7:0]            shown;
      logic [2:0]            base;
      logic [CLK_REGS-1:0][7:0] vals;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

endpackage

`default_nettype wire

### rtl/core/cts_front.sv
`default_nettype none

module cts_front
   import cts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire req_type      req,
   output cmd_type          cmd
);

   pos_type               pos_ff, pos_in;
   logic [11:1][7:0]      fld_ff, fld_in;
   logic [7:0]            cur;
   logic [7:0]            nv;

   function automatic logic [7:0] bcd_in(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
   endfunction

   function automatic logic [7:0] step(input pos_type p, input logic up,
                                        input logic [7:0] v);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'd0;
      hi = 8'd59;
      unique case (p)
         POS_DATE:  begin lo = 8'd1; hi = 8'd31; end
         POS_MONTH: begin lo = 8'd1; hi = 8'd12; end
         POS_YEAR:  hi = 8'd99;
         POS_HOUR, POS_ON_HOUR, POS_OFF_HOUR: hi = 8'd23;
         default:   hi = 8'd59;
      endcase
      if (p == POS_WDAY) begin
         // weekday wraps 1..7
         if (up) return (v >= 8'd7) ? 8'd1 : v + 8'd1;
         else    return (v <= 8'd1) ? 8'd7 : v - 8'd1;
      end
      if (up) return (v >= hi) ? hi : v + 8'd1;
      else    return (v <= lo) ? lo : v - 8'd1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_RUN;
         fld_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         fld_ff <= fld_in;
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      fld_in    = fld_ff;
      cmd       = '0;
      cmd.kind  = CMD_SINGLE;
      cmd.state = pos_ff;
      cur       = '0;
      if (pos_ff != POS_RUN) cur = fld_ff[pos_ff];
      cmd.shown = cur;
      nv        = step(pos_ff, req.mode == MODE_PLUS, cur);
      if (accept) begin
         if (pos_ff == POS_RUN) begin
            unique case (mode_type'(req.mode))
               MODE_SNAP: begin
                  fld_in[POS_SEC]   = bcd_in(req.sec_bcd);
                  fld_in[POS_MIN]   = bcd_in(req.min_bcd);
                  fld_in[POS_HOUR]  = bcd_in(req.hour_bcd);
                  fld_in[POS_WDAY]  = req.weekday_raw;
                  fld_in[POS_DATE]  = bcd_in(req.date_bcd);
                  fld_in[POS_MONTH] = bcd_in(req.month_bcd);
                  fld_in[POS_YEAR]  = bcd_in(req.year_bcd);
               end
               MODE_CLOCK: begin
                  pos_in    = POS_DATE;
                  cmd.shown = fld_ff[POS_DATE];
               end
               MODE_START: begin
                  pos_in    = POS_ON_HOUR;
                  cmd.shown = fld_ff[POS_ON_HOUR];
               end
               MODE_STOP: begin
                  pos_in    = POS_OFF_HOUR;
                  cmd.shown = fld_ff[POS_OFF_HOUR];
               end
               default: ;
            endcase
            cmd.state = pos_in;
         end else begin
            unique case (mode_type'(req.mode))
               MODE_PLUS, MODE_MINUS: begin
                  fld_in[pos_ff] = nv;
                  cmd.shown      = nv;
               end
               MODE_SET: begin
                  priority if (pos_ff == POS_SEC) begin
                     pos_in       = POS_RUN;
                     cmd.kind     = CMD_CLOCK;
                     cmd.state    = POS_RUN;
                     cmd.shown    = '0;
                     cmd.vals[0]  = fld_ff[POS_SEC];
                     cmd.vals[1]  = fld_ff[POS_MIN];
                     cmd.vals[2]  = fld_ff[POS_HOUR];
                     cmd.vals[3]  = fld_ff[POS_WDAY];
                     cmd.vals[4]  = fld_ff[POS_DATE];
                     cmd.vals[5]  = fld_ff[POS_MONTH];
                     cmd.vals[6]  = fld_ff[POS_YEAR];
                  end else if (pos_ff == POS_ON_MIN) begin
                     pos_in      = POS_RUN;
                     cmd.kind    = CMD_NV;
                     cmd.state   = POS_RUN;
                     cmd.shown   = '0;
                     cmd.base    = NV_ON_BASE;
                     cmd.vals[0] = fld_ff[POS_ON_HOUR];
                     cmd.vals[1] = fld_ff[POS_ON_MIN];
                  end else if (pos_ff == POS_OFF_MIN) begin
                     pos_in      = POS_RUN;
                     cmd.kind    = CMD_NV;
                     cmd.state   = POS_RUN;
                     cmd.shown   = '0;
                     cmd.base    = NV_OFF_BASE;
                     cmd.vals[0] = fld_ff[POS_OFF_HOUR];
                     cmd.vals[1] = fld_ff[POS_OFF_MIN];
                  end else begin
                     pos_in    = pos_type'(pos_ff + 4'd1);
                     cmd.state = pos_in;
                     cmd.shown = fld_ff[pos_in];
                  end
               end
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/cts_queue.sv
`default_nettype none

module cts_queue
   import cts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire cmd_type      push_cmd,
   input  wire logic         pop,
   output cmd_type          head,
   output q_status_type     status
);

   cmd_type      slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.valid = (cnt_ff != 2'd0);
   assign status.full  = (cnt_ff == 2'd2);

endmodule

`default_nettype wire

### rtl/core/cts_back.sv
`default_nettype none

module cts_back
   import cts_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      head,
   input  wire q_status_type status,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_type          rsp_word
);

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   rsp_type     word_ff, word_in;
   logic        adv;
   logic        fin;
   logic [7:0]  val;

   // v/10 by reciprocal, exact for all 8-bit v
   function automatic logic [7:0] bcd_out(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  r;
      prod = {8'd0, v} * 16'd205;
      q    = prod[15:11];
      r    = v - ({3'd0, q} << 3) - ({3'd0, q} << 1);
      return {q[3:0], r[3:0]};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_comb begin
      adv      = !valid_ff || !rsp_stall;
      val      = head.vals[idx_ff];
      fin      = 1'b1;
      word_in  = word_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      unique case (head.kind)
         CMD_CLOCK: fin = (idx_ff == LAST_CLK_REG);
         CMD_NV:    fin = (idx_ff == LAST_NV_REG);
         default:   fin = 1'b1;
      endcase
      if (adv) begin
         valid_in = status.valid;
         if (status.valid) begin
            word_in               = '0;
            word_in.menu_state    = head.state;
            word_in.shown_value   = head.shown;
            word_in.last          = fin;
            unique case (head.kind)
               CMD_CLOCK: begin
                  word_in.write_target  = TGT_CLOCK;
                  word_in.write_address = idx_ff;
                  // weekday goes out unconverted
                  word_in.write_data    = (idx_ff == WDAY_REG) ? val : bcd_out(val);
               end
               CMD_NV: begin
                  word_in.write_target  = TGT_NV;
                  word_in.write_address = head.base + idx_ff;
                  word_in.write_data    = val;
               end
               default: word_in.write_target = TGT_NONE;
            endcase
            pop    = fin;
            idx_in = fin ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

### rtl/core/clock_time_set_menu.sv
`default_nettype none

// channel | ports                         | word type | accepted when
// --------+-------------------------------+-----------+--------------------
// input   | req_valid req_stall req_word  | req_type  | req_valid & !req_stall
// result  | rsp_valid rsp_stall rsp_word  | rsp_type  | rsp_valid & !rsp_stall
//
// Results: the back end sends one result word per cycle unless rsp_stall
// holds it; a snapshot or key gives one word, a start/stop store two and a
// clock store seven.
// Reset: synchronous, clears the menu position, held fields, queue and output.
// Stalls: a two-deep command queue sits between front and back; req_stall
// rises only when it is full, rsp_stall only freezes the back end.

module clock_time_set_menu
   import cts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic        req_stall,
   input  wire req_type req_word,
   output logic        rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type     rsp_word
);

   logic         accept;
   logic         pop;
   cmd_type      cmd;
   cmd_type      head;
   q_status_type status;

   // front applies the word to the menu state at once; back replays results
   assign req_stall = status.full;
   assign accept    = req_valid && !status.full;

   cts_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_word),
      .cmd    (cmd)
   );

   cts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .status   (status)
   );

   cts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .status    (status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

### rtl/core/cts_checker.sv
`default_nettype none

module cts_checker
   import cts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_word
);

   // stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_plain_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.write_target == TGT_NONE |-> rsp_word.last)
      else $error("word without write not last");

   a_burst_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.write_target != TGT_NONE |->
         rsp_word.menu_state == POS_RUN && rsp_word.shown_value == 8'd0)
      else $error("write word not in run state");

   a_clk_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.write_target == TGT_CLOCK && rsp_word.last |->
         rsp_word.write_address == LAST_CLK_REG)
      else $error("clock burst ends early");

endmodule

bind clock_time_set_menu cts_checker u_cts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import cts_pkg::*;

   // mode code the block has no use for; must be swallowed like a bad key
   localparam logic [2:0] MODE_UNUSED  = 3'd7;
   localparam int         RANDOM_ITEMS = 240;
   localparam int         CALM_ITEMS   = 40;    // tail of the run with no idling
   localparam int         DRAIN_CYCLES = 16;
   localparam int         LIMIT_CYCLES = 200_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   clock_time_set_menu u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Menu predictor
   // held[] is indexed by menu position, so held[POS_RUN] stays 0 and
   // gives the shown value while running for free.
   // ---------------------------------------------------------------------
   logic [3:0] menu_pos;
   logic [7:0] held [0:15];
   rsp_type    pending_menu_words [$];

   int fail_count    = 0;
   int words_checked = 0;
   int items_sent    = 0;
   int clock_stores  = 0;
   int nv_stores     = 0;
   bit idling        = 1'b0;
   int stall_left    = 0;

   function automatic logic [7:0] from_bcd(logic [7:0] b);
      return 8'(b[7:4] * 8'd10 + b[3:0]);
   endfunction

   // out-of-range values overflow the high digit; only the low byte survives
   function automatic logic [7:0] to_bcd(logic [7:0] v);
      logic [11:0] t;
      t = ({4'b0, v / 8'd10} << 4) | 12'(v % 8'd10);
      return t[7:0];
   endfunction

   function automatic void clear_menu();
      menu_pos = POS_RUN;
      for (int i = 0; i < 16; i++) held[i] = 8'd0;
   endfunction

   function automatic void queue_word(logic [1:0] tgt, logic [2:0] addr,
                                      logic [7:0] data, bit is_last);
      rsp_type r;
      r.menu_state    = menu_pos;
      r.shown_value   = held[menu_pos];
      r.write_target  = tgt;
      r.write_address = addr;
      r.write_data    = data;
      r.last          = is_last;
      pending_menu_words.push_back(r);
   endfunction

   function automatic void predict_menu(req_type w);
      logic [7:0] v, lo, hi;
      logic [7:0] burst [0:6];
      logic [2:0] base;
      logic [7:0] hr, mn;
      if (menu_pos == POS_RUN) begin
         case (w.mode)
            MODE_SNAP: begin
               held[POS_SEC]   = from_bcd(w.sec_bcd);
               held[POS_MIN]   = from_bcd(w.min_bcd);
               held[POS_HOUR]  = from_bcd(w.hour_bcd);
               held[POS_WDAY]  = w.weekday_raw;
               held[POS_DATE]  = from_bcd(w.date_bcd);
               held[POS_MONTH] = from_bcd(w.month_bcd);
               held[POS_YEAR]  = from_bcd(w.year_bcd);
            end
            MODE_CLOCK: menu_pos = POS_DATE;
            MODE_START: menu_pos = POS_ON_HOUR;
            MODE_STOP:  menu_pos = POS_OFF_HOUR;
            default: ;
         endcase
      end else if (w.mode == MODE_PLUS || w.mode == MODE_MINUS) begin
         v = held[menu_pos];
         if (menu_pos == POS_WDAY) begin
            // weekday wraps 1..7 instead of saturating
            if (w.mode == MODE_PLUS) v = (v >= 8'd7) ? 8'd1 : v + 8'd1;
            else                     v = (v <= 8'd1) ? 8'd7 : v - 8'd1;
         end else begin
            case (menu_pos)
               POS_DATE:  begin lo = 8'd1; hi = 8'd31; end
               POS_MONTH: begin lo = 8'd1; hi = 8'd12; end
               POS_YEAR:  begin lo = 8'd0; hi = 8'd99; end
               POS_HOUR, POS_ON_HOUR, POS_OFF_HOUR: begin
                  lo = 8'd0; hi = 8'd23;
               end
               default:   begin lo = 8'd0; hi = 8'd59; end
            endcase
            if (w.mode == MODE_PLUS) v = (v >= hi) ? hi : v + 8'd1;
            else                     v = (v <= lo) ? lo : v - 8'd1;
         end
         held[menu_pos] = v;
      end else if (w.mode == MODE_SET) begin
         if (menu_pos == POS_SEC) begin
            burst[0] = to_bcd(held[POS_SEC]);
            burst[1] = to_bcd(held[POS_MIN]);
            burst[2] = to_bcd(held[POS_HOUR]);
            burst[3] = held[POS_WDAY];
            burst[4] = to_bcd(held[POS_DATE]);
            burst[5] = to_bcd(held[POS_MONTH]);
            burst[6] = to_bcd(held[POS_YEAR]);
            menu_pos = POS_RUN;
            for (int k = 0; k < 7; k++) queue_word(TGT_CLOCK, 3'(k), burst[k], k == 6);
            clock_stores++;
            return;
         end
         if (menu_pos == POS_ON_MIN || menu_pos == POS_OFF_MIN) begin
            base     = (menu_pos == POS_ON_MIN) ? NV_ON_BASE : NV_OFF_BASE;
            hr       = held[menu_pos - 4'd1];
            mn       = held[menu_pos];
            menu_pos = POS_RUN;
            queue_word(TGT_NV, base, hr, 1'b0);
            queue_word(TGT_NV, base + 3'd1, mn, 1'b1);
            nv_stores++;
            return;
         end
         menu_pos = menu_pos + 4'd1;
      end
      // snapshot/keys while editing and mode 7 fall through untouched
      queue_word(TGT_NONE, 3'd0, 8'd0, 1'b1);
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every accepted word against the oldest prediction
   // ---------------------------------------------------------------------
   rsp_type want_word;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_checked++;
         if (pending_menu_words.size() == 0) begin
            $error("result word %h with nothing expected", rsp_word);
            fail_count++;
         end else begin
            want_word = pending_menu_words.pop_front();
            if (rsp_word.menu_state !== want_word.menu_state) begin
               $error("menu_state: expected %0d, got %0d",
                      want_word.menu_state, rsp_word.menu_state);
               fail_count++;
            end
            if (rsp_word.shown_value !== want_word.shown_value) begin
               $error("shown_value: expected %0d, got %0d",
                      want_word.shown_value, rsp_word.shown_value);
               fail_count++;
            end
            if (rsp_word.write_target !== want_word.write_target) begin
               $error("write_target: expected %0d, got %0d",
                      want_word.write_target, rsp_word.write_target);
               fail_count++;
            end
            if (rsp_word.write_address !== want_word.write_address) begin
               $error("write_address: expected %0d, got %0d",
                      want_word.write_address, rsp_word.write_address);
               fail_count++;
            end
            if (rsp_word.write_data !== want_word.write_data) begin
               $error("write_data: expected %h, got %h",
                      want_word.write_data, rsp_word.write_data);
               fail_count++;
            end
            if (rsp_word.last !== want_word.last) begin
               $error("last: expected %0d, got %0d", want_word.last, rsp_word.last);
               fail_count++;
            end
         end
      end
   end

   // result-side backpressure in bursts of random length while idling is on
   always @(posedge clock) begin
      if (reset || !idling) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Valid stays high from one word to the next unless a gap is taken,
   // so it is never lowered and raised within one time step.
   task automatic send_word(input logic [2:0] mode, input req_type payload);
      req_type w;
      w      = payload;
      w.mode = mode;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predict_menu(w);
      items_sent++;
   endtask

   // half the time a clean BCD time, otherwise raw bytes
   function automatic req_type random_payload();
      req_type w;
      w.mode = MODE_SNAP;
      if ($urandom_range(0, 1)) begin
         w.sec_bcd     = to_bcd(8'($urandom_range(0, 59)));
         w.min_bcd     = to_bcd(8'($urandom_range(0, 59)));
         w.hour_bcd    = to_bcd(8'($urandom_range(0, 23)));
         w.weekday_raw = 8'($urandom_range(1, 7));
         w.date_bcd    = to_bcd(8'($urandom_range(1, 31)));
         w.month_bcd   = to_bcd(8'($urandom_range(1, 12)));
         w.year_bcd    = to_bcd(8'($urandom_range(0, 99)));
      end else begin
         w.sec_bcd     = 8'($urandom);
         w.min_bcd     = 8'($urandom);
         w.hour_bcd    = 8'($urandom);
         w.weekday_raw = 8'($urandom);
         w.date_bcd    = 8'($urandom);
         w.month_bcd   = 8'($urandom);
         w.year_bcd    = 8'($urandom);
      end
      return w;
   endfunction

   task automatic press(input logic [2:0] mode);
      send_word(mode, random_payload());
   endtask

   task automatic send_snapshot(input logic [7:0] fill);
      req_type w;
      w = {MODE_SNAP, {7{fill}}};
      send_word(MODE_SNAP, w);
   endtask

   // a few plus/minus presses, now and then a long run into the bound, maybe a stray key, then set
   task automatic edit_field();
      int         presses;
      logic [2:0] dir;
      presses = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 3);
      dir     = $urandom_range(0, 1) ? MODE_PLUS : MODE_MINUS;
      repeat (presses) begin
         if ($urandom_range(0, 3) == 0) dir = $urandom_range(0, 1) ? MODE_PLUS : MODE_MINUS;
         press(dir);
      end
      if ($urandom_range(0, 12) == 0) press(3'($urandom_range(0, 7)));
      press(MODE_SET);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // all-zero snapshot, then all-ones: every BCD byte decodes to 165 (out of range), weekday stays 255
   task automatic test_snapshot_decode();
      send_snapshot(8'h00);
      send_snapshot(8'hFF);
   endtask

   // edit keys while running and the unused mode must change nothing
   task automatic test_ignored_keys();
      press(MODE_PLUS);
      press(MODE_SET);
      press(MODE_UNUSED);
   endtask

   // walk the clock chain starting from the out-of-range fields
   task automatic test_clock_chain();
      press(MODE_CLOCK);
      press(MODE_MINUS);     // date 165 -> 164, kept above range
      press(MODE_PLUS);      // clamps to 31
      press(MODE_SET);
      press(MODE_SET);       // month left at 165
      press(MODE_MINUS);     // year 165 -> 164
      press(MODE_SET);
      press(MODE_PLUS);      // weekday 255 wraps to 1
      press(MODE_MINUS);     // 1 wraps to 7
      press(MODE_SET);
      send_snapshot(8'h42);  // snapshot while editing: dropped
      press(MODE_UNUSED);
      press(MODE_SET);
      press(MODE_SET);
      press(MODE_SET);       // clock store to all clock registers, overflowing BCD bytes
   endtask

   task automatic test_switch_times();
      press(MODE_START);
      press(MODE_MINUS);     // hour 0 stays at 0
      press(MODE_SET);
      press(MODE_SET);       // two nonvolatile writes at base 0
      press(MODE_STOP);
      press(MODE_PLUS);
      press(MODE_SET);
      press(MODE_SET);       // two nonvolatile writes at base 2
   endtask

   // Mostly whole chains with random edits, some snapshots, some noise.
   task automatic test_random_sessions();
      int first;
      int pick;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         idling = (items_sent - first < RANDOM_ITEMS - CALM_ITEMS) &&
                  ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            send_word(MODE_SNAP, random_payload());
         end else if (pick < 5) begin
            press(MODE_CLOCK);
            repeat (7) edit_field();
         end else if (pick < 8) begin
            press($urandom_range(0, 1) ? MODE_START : MODE_STOP);
            repeat (2) edit_field();
         end else begin
            repeat ($urandom_range(1, 3)) press(3'($urandom_range(0, 7)));
         end
      end
      idling = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      clear_menu();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_snapshot_decode();
      test_ignored_keys();
      test_clock_chain();
      test_switch_times();
      test_random_sessions();

      req_valid <= 1'b0;
      while (pending_menu_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words, checked %0d results:", items_sent, words_checked);
      $display("%0d clock-chip stores, %0d switch-time stores.", clock_stores, nv_stores);
      if (fail_count == 0 && pending_menu_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("Timed out with %0d results outstanding", pending_menu_words.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

### clock_time_set_menu.f
rtl/core/cts_pkg.sv
rtl/core/cts_front.sv
rtl/core/cts_queue.sv
rtl/core/cts_back.sv
rtl/core/clock_time_set_menu.sv
rtl/core/cts_checker.sv
dv/tb_top.sv
